[rtl/core/eta_pkg.sv]
package eta_pkg;

  localparam int unsigned ENTRIES_DEF = 1024;

  localparam logic [2:0] OP_WRITE   = 3'd0;
  localparam logic [2:0] OP_READ    = 3'd1;
  localparam logic [2:0] OP_FREE    = 3'd2;
  localparam logic [2:0] OP_RESERVE = 3'd3;
  localparam logic [2:0] OP_ALLOC   = 3'd4;
  localparam logic [2:0] OP_FIND    = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFREE  = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;

  localparam logic [4:0]  BLK_LOG2_RESET = 5'd12;
  localparam logic [4:0]  BLK_LOG2_MIN   = 5'd9;
  localparam logic [4:0]  BLK_LOG2_MAX   = 5'd16;
  localparam logic [47:0] BIG_HOLE       = 48'h10_0000;
  localparam logic [47:0] SIZE_CAP       = 48'hFFFF_FFFF;
  localparam logic [30:0] KEY_MAX        = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [9:0]         entry_index;
    logic signed [31:0] owner_id;
    logic [2:0]         entry_kind;
    logic [30:0]        start_block;
    logic [31:0]        byte_size;
    logic [47:0]        max_bytes;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [9:0]         result_index;
    logic signed [31:0] result_id;
    logic [2:0]         result_kind;
    logic [30:0]        result_start;
    logic [31:0]        result_size;
  } out_word_t;

  typedef struct packed {
    logic [31:0] owner;
    logic [2:0]  kind;
    logic [30:0] start;
    logic [31:0] size;
  } entry_t;

endpackage

[rtl/core/extent_table_allocator_unit.sv]
// extent table allocator: a table of ENTRIES extents (owner, kind, start block, byte size)
// kept in one memory, plus an order list sorted by start block (unused entries last, ties
// by index) held in a second, double-banked memory that is rebuilt bank to bank on every
// change. one operation per input word, one result word each. after reset a clearing
// pass over all ENTRIES runs before the first word is taken (config writes still land).
// read fetches one entry; find scans from entry_index for a matching owner; write and
// free rewrite one entry and re-sort the order list; reserve scans every entry and then
// re-sorts; allocate scans for a free entry after entry_index, walks the used extents in
// start order (order-list read, entry read, compare), then re-sorts. both memory ports
// take one read per cycle. the result sits in an output register, so a waiting consumer
// only stalls the block when the next result is ready.
module extent_table_allocator_unit #(
  parameter int unsigned ENTRIES = eta_pkg::ENTRIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  eta_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output eta_pkg::out_word_t out_word_o,
  input  logic               cfg_we_i,
  input  logic [4:0]         cfg_wdata_i
);

  localparam int unsigned IW = $clog2(ENTRIES);
  // counters must hold ENTRIES and entry_index + 1
  localparam int unsigned CW = (IW + 1 > 11) ? IW + 1 : 11;
  localparam logic [CW-1:0] NUM = CW'(ENTRIES);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_FRD  = 4'd2;
  localparam logic [3:0] S_FMOD = 4'd3;
  localparam logic [3:0] S_SCAN = 4'd4;
  localparam logic [3:0] S_ORD  = 4'd5;
  localparam logic [3:0] S_OEN  = 4'd6;
  localparam logic [3:0] S_ACMP = 4'd7;
  localparam logic [3:0] S_RCMP = 4'd8;
  localparam logic [3:0] S_WR   = 4'd9;
  localparam logic [3:0] S_EMIT = 4'd10;

  // memories
  eta_pkg::entry_t ent_mem [ENTRIES];
  logic [IW-1:0]   ord_mem [2*ENTRIES];

  logic [3:0]         state_q;
  eta_pkg::in_word_t  in_q;
  eta_pkg::entry_t    ent_q;
  eta_pkg::entry_t    ent_rd_q;
  logic [IW-1:0]      ord_rd_q;
  logic [IW-1:0]      tgt_q;
  logic [IW-1:0]      e_q;
  logic [IW-1:0]      pidx_q;
  logic [IW-1:0]      ff_q;
  logic [CW-1:0]      cnt_q;
  logic [CW-1:0]      w_q;
  logic               pend_q;
  logic               hf_q;
  logic               ins_q;
  logic               alloc_q;
  logic               first_q;
  logic               bank_q;
  logic [31:0]        prev_end_q;
  logic signed [31:0] mx_q;
  logic [1:0]         stat_q;
  logic [4:0]         blk_q;
  logic               out_valid_q;
  eta_pkg::out_word_t out_q;

  // memory ports
  logic            ent_we;
  logic [IW-1:0]   ent_waddr;
  logic [IW-1:0]   ent_raddr;
  eta_pkg::entry_t ent_wdata;
  logic            ord_we;
  logic [IW:0]     ord_waddr;
  logic [IW-1:0]   ord_wdata;

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rd_q <= ent_mem[ent_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    ord_rd_q <= ord_mem[{bank_q, cnt_q[IW-1:0]}];
  end

  // block size clamp
  logic [4:0] blk;
  always_comb begin
    blk = blk_q;
    if (blk_q < eta_pkg::BLK_LOG2_MIN) blk = eta_pkg::BLK_LOG2_MIN;
    if (blk_q > eta_pkg::BLK_LOG2_MAX) blk = eta_pkg::BLK_LOG2_MAX;
  end

  // entry just read and the key compare for the re-sort
  logic        r_used, t_used, tgt_ahead;
  logic [30:0] r_key, t_key;
  logic [31:0] r_end;
  assign r_used    = (ent_rd_q.owner != '1) && (ent_rd_q.size != '0);
  assign t_used    = (ent_q.owner != '1) && (ent_q.size != '0);
  assign r_key     = r_used ? ent_rd_q.start : eta_pkg::KEY_MAX;
  assign t_key     = t_used ? ent_q.start : eta_pkg::KEY_MAX;
  assign tgt_ahead = (t_key < r_key) || ((t_key == r_key) && (tgt_q < e_q));
  assign r_end     = {1'b0, ent_rd_q.start} + ((ent_rd_q.size - 32'd1) >> blk) + 32'd1;

  // hole between previous used extent and this one
  logic        gap_pos, hole_ok;
  logic [31:0] gap;
  logic [47:0] hole, hole_sz;
  logic [47:0] end_sz;
  logic [30:0] end_start;
  assign gap_pos = {1'b0, ent_rd_q.start} > prev_end_q;
  assign gap     = {1'b0, ent_rd_q.start} - prev_end_q;
  assign hole    = {16'd0, gap} << blk;
  assign hole_ok = gap_pos && ((hole > eta_pkg::BIG_HOLE) || (hole > (in_q.max_bytes >> 2)));
  always_comb begin
    hole_sz = (in_q.max_bytes < hole) ? in_q.max_bytes : hole;
    if (hole_sz > eta_pkg::SIZE_CAP) hole_sz = eta_pkg::SIZE_CAP;
    end_sz = (in_q.max_bytes > eta_pkg::SIZE_CAP) ? eta_pkg::SIZE_CAP : in_q.max_bytes;
    if (first_q) begin
      end_start = '0;
    end else if (prev_end_q > {1'b0, eta_pkg::KEY_MAX}) begin
      end_start = eta_pkg::KEY_MAX;
    end else begin
      end_start = prev_end_q[30:0];
    end
  end

  logic          in_acc, idx_oob, scan_issue, alloc_hit;
  logic [CW-1:0] idx_ext;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign idx_ext    = CW'(in_word_i.entry_index);
  assign idx_oob    = idx_ext >= NUM;
  assign scan_issue = cnt_q < NUM;
  // free entry found during the allocate scan
  assign alloc_hit  = (in_q.opcode == eta_pkg::OP_ALLOC) && pend_q && (ent_rd_q.owner == '1);

  // memory port control
  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = tgt_q;
    ent_wdata = ent_q;
    ent_raddr = tgt_q;
    ord_we    = 1'b0;
    ord_waddr = {~bank_q, w_q[IW-1:0]};
    ord_wdata = tgt_q;
    case (state_q)
      S_CLR: begin
        ent_we    = 1'b1;
        ent_waddr = cnt_q[IW-1:0];
        ent_wdata = '{owner: '1, kind: '0, start: '0, size: '0};
        ord_we    = 1'b1;
        ord_waddr = {1'b0, cnt_q[IW-1:0]};
        ord_wdata = cnt_q[IW-1:0];
      end
      S_WR: ent_we = 1'b1;
      S_SCAN: ent_raddr = cnt_q[IW-1:0];
      S_OEN: ent_raddr = ord_rd_q;
      S_ACMP: ent_raddr = e_q;
      S_RCMP: begin
        ent_raddr = e_q;
        if (e_q != tgt_q) begin
          ord_we    = 1'b1;
          ord_wdata = (!ins_q && tgt_ahead) ? tgt_q : e_q;
        end
      end
      S_ORD: begin
        // target goes last if nothing came after it
        if (!alloc_q && cnt_q == NUM && !ins_q) begin
          ord_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_q <= eta_pkg::BLK_LOG2_RESET;
    end else if (cfg_we_i) begin
      blk_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      in_q        <= '0;
      ent_q       <= '0;
      tgt_q       <= '0;
      e_q         <= '0;
      pidx_q      <= '0;
      ff_q        <= '0;
      cnt_q       <= '0;
      w_q         <= '0;
      pend_q      <= 1'b0;
      hf_q        <= 1'b0;
      ins_q       <= 1'b0;
      alloc_q     <= 1'b0;
      first_q     <= 1'b1;
      bank_q      <= 1'b0;
      prev_end_q  <= '0;
      mx_q        <= '0;
      stat_q      <= eta_pkg::ST_OK;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // the emit state handles its own handover
      if (out_valid_q && out_ready_i && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == NUM - 1'b1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            in_q   <= in_word_i;
            tgt_q  <= IW'(in_word_i.entry_index);
            stat_q <= eta_pkg::ST_OK;
            pend_q <= 1'b0;
            hf_q   <= 1'b0;
            case (in_word_i.opcode)
              eta_pkg::OP_WRITE: begin
                if (idx_oob) begin
                  stat_q  <= eta_pkg::ST_NOMATCH;
                  state_q <= S_EMIT;
                end else begin
                  ent_q   <= '{owner: in_word_i.owner_id, kind: in_word_i.entry_kind,
                               start: in_word_i.start_block, size: in_word_i.byte_size};
                  state_q <= S_WR;
                end
              end
              eta_pkg::OP_READ, eta_pkg::OP_FREE: begin
                if (idx_oob) begin
                  stat_q  <= eta_pkg::ST_NOMATCH;
                  state_q <= S_EMIT;
                end else begin
                  state_q <= S_FRD;
                end
              end
              eta_pkg::OP_RESERVE: begin
                cnt_q   <= '0;
                mx_q    <= -32'sd1;
                state_q <= S_SCAN;
              end
              eta_pkg::OP_ALLOC: begin
                cnt_q   <= idx_ext + 1'b1;
                state_q <= S_SCAN;
              end
              eta_pkg::OP_FIND: begin
                cnt_q   <= idx_ext;
                state_q <= S_SCAN;
              end
              default: begin
                stat_q  <= eta_pkg::ST_NOMATCH;
                state_q <= S_EMIT;
              end
            endcase
          end
        end
        S_FRD: state_q <= S_FMOD;
        S_FMOD: begin
          if (in_q.opcode == eta_pkg::OP_READ) begin
            ent_q   <= ent_rd_q;
            state_q <= S_EMIT;
          end else begin
            ent_q   <= '{owner: '1, kind: '0, start: ent_rd_q.start, size: ent_rd_q.size};
            state_q <= S_WR;
          end
        end
        S_SCAN: begin
          // one read issued per cycle, data checked in the next cycle
          if (scan_issue && !alloc_hit) begin
            cnt_q <= cnt_q + 1'b1;
          end
          pend_q <= scan_issue;
          pidx_q <= cnt_q[IW-1:0];
          case (in_q.opcode)
            eta_pkg::OP_RESERVE: begin
              if (pend_q) begin
                if ($signed(ent_rd_q.owner) > mx_q) mx_q <= $signed(ent_rd_q.owner);
                if (ent_rd_q.owner == '1 && !hf_q) begin
                  hf_q <= 1'b1;
                  ff_q <= pidx_q;
                end
              end
              if (!scan_issue && !pend_q) begin
                if (mx_q == 32'sh7FFF_FFFF || !hf_q) begin
                  stat_q  <= eta_pkg::ST_NOFREE;
                  state_q <= S_EMIT;
                end else begin
                  ent_q   <= '{owner: mx_q + 32'sd1, kind: in_q.entry_kind,
                               start: '0, size: '0};
                  tgt_q   <= ff_q;
                  state_q <= S_WR;
                end
              end
            end
            eta_pkg::OP_ALLOC: begin
              if (alloc_hit) begin
                tgt_q      <= pidx_q;
                cnt_q      <= '0;
                alloc_q    <= 1'b1;
                first_q    <= 1'b1;
                prev_end_q <= '0;
                state_q    <= S_ORD;
              end else if (!scan_issue && !pend_q) begin
                stat_q  <= eta_pkg::ST_NOFREE;
                state_q <= S_EMIT;
              end
            end
            default: begin
              if (pend_q && ent_rd_q.owner == in_q.owner_id) begin
                tgt_q   <= pidx_q;
                ent_q   <= ent_rd_q;
                state_q <= S_EMIT;
              end else if (!scan_issue && !pend_q) begin
                stat_q  <= eta_pkg::ST_NOMATCH;
                state_q <= S_EMIT;
              end
            end
          endcase
        end
        S_ORD: begin
          if (cnt_q == NUM) begin
            if (alloc_q) begin
              // every entry used: place after the last one
              ent_q   <= '{owner: in_q.owner_id, kind: in_q.entry_kind,
                           start: end_start, size: end_sz[31:0]};
              state_q <= S_WR;
            end else begin
              bank_q  <= ~bank_q;
              state_q <= S_EMIT;
            end
          end else begin
            state_q <= S_OEN;
          end
        end
        S_OEN: begin
          e_q     <= ord_rd_q;
          state_q <= alloc_q ? S_ACMP : S_RCMP;
        end
        S_ACMP: begin
          if (!r_used) begin
            ent_q   <= '{owner: in_q.owner_id, kind: in_q.entry_kind,
                         start: end_start, size: end_sz[31:0]};
            state_q <= S_WR;
          end else if (!first_q && hole_ok) begin
            ent_q   <= '{owner: in_q.owner_id, kind: in_q.entry_kind,
                         start: prev_end_q[30:0], size: hole_sz[31:0]};
            state_q <= S_WR;
          end else begin
            first_q    <= 1'b0;
            prev_end_q <= r_end;
            cnt_q      <= cnt_q + 1'b1;
            state_q    <= S_ORD;
          end
        end
        S_RCMP: begin
          if (e_q == tgt_q) begin
            cnt_q   <= cnt_q + 1'b1;
            state_q <= S_ORD;
          end else if (!ins_q && tgt_ahead) begin
            // target written here, current element goes next cycle
            w_q   <= w_q + 1'b1;
            ins_q <= 1'b1;
          end else begin
            w_q     <= w_q + 1'b1;
            cnt_q   <= cnt_q + 1'b1;
            state_q <= S_ORD;
          end
        end
        S_WR: begin
          cnt_q   <= '0;
          w_q     <= '0;
          ins_q   <= 1'b0;
          alloc_q <= 1'b0;
          state_q <= S_ORD;
        end
        S_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            if (stat_q == eta_pkg::ST_OK) begin
              out_q <= '{status: stat_q, result_index: 10'(tgt_q),
                         result_id: ent_q.owner, result_kind: ent_q.kind,
                         result_start: ent_q.start, result_size: ent_q.size};
            end else begin
              out_q <= '{status: stat_q, default: '0};
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
